[rtl/core/bicolor_led_matrix_scan_shifter_defines.svh]
// assertion macros shared by the scan shifter modules
`ifndef BICOLOR_LED_MATRIX_SCAN_SHIFTER_DEFINES_SVH
`define BICOLOR_LED_MATRIX_SCAN_SHIFTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BLMSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BLMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/blmss_pkg.sv]
// shared constants, tables and types of the led matrix scan shifter
`timescale 1ns / 1ps

package blmss_pkg;

  localparam int ROW_BITS   = 16;
  localparam int COL_BITS   = 8;
  localparam int SHIFT_BITS = ROW_BITS + COL_BITS;
  localparam int POS_W      = $clog2(SHIFT_BITS);
  localparam int SLOT_W     = 7;
  localparam int FRAME_W    = 64;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SHIFT_BITS - 1);

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // shift order of the active-low row lines
  localparam logic [3:0] ROW_ORDER [ROW_BITS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd15,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd7
  };

  // shift order of the column lines
  localparam logic [2:0] COL_ORDER [COL_BITS] = '{
    3'd4, 3'd5, 3'd6, 3'd7, 3'd3, 3'd2, 3'd1, 3'd0
  };

  // one slot worth of chain bits, bit 0 shifted first
  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [SHIFT_BITS-1:0] bits;
  } pattern_t;

endpackage

[rtl/core/blmss_frame_store.sv]
// frame registers, slot counter and per-slot chain pattern generation
`timescale 1ns / 1ps

module blmss_frame_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load_en,
  input  logic                             tick_en,
  input  logic [blmss_pkg::FRAME_W-1:0]    red_frame,
  input  logic [blmss_pkg::FRAME_W-1:0]    yellow_frame,
  output blmss_pkg::pattern_t              pattern
);

  logic [blmss_pkg::FRAME_W-1:0] red_r;
  logic [blmss_pkg::FRAME_W-1:0] yellow_r;
  logic [blmss_pkg::SLOT_W-1:0]  slot_r;
  logic [blmss_pkg::SLOT_W-1:0]  slot_nxt;

  logic [2:0] col_x;
  logic       color;
  logic [2:0] row_y;
  logic [3:0] row_target;
  logic       lit;

  // frames and slot counter
  assign slot_nxt = slot_r + blmss_pkg::SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r    <= '0;
      yellow_r <= '0;
      slot_r   <= '0;
    end else begin
      if (load_en) begin
        red_r    <= red_frame;
        yellow_r <= yellow_frame;
      end
      if (tick_en) begin
        slot_r <= slot_nxt;
      end
    end
  end

  // decode the current slot into column, color and row
  assign col_x      = slot_r[6:4];
  assign color      = slot_r[3];
  assign row_y      = slot_r[2:0];
  assign row_target = {color, row_y};
  assign lit        = color ? yellow_r[{row_y, col_x}] : red_r[{row_y, col_x}];

  // chain bits: rows first, then columns; a dark dot drives nothing
  always_comb begin
    pattern.slot = slot_r;
    for (int i = 0; i < blmss_pkg::ROW_BITS; i++) begin
      pattern.bits[i] = !lit || (blmss_pkg::ROW_ORDER[i] != row_target);
    end
    for (int j = 0; j < blmss_pkg::COL_BITS; j++) begin
      pattern.bits[blmss_pkg::ROW_BITS + j] = lit && (blmss_pkg::COL_ORDER[j] == col_x);
    end
  end

endmodule

[rtl/core/blmss_serializer.sv]
// one-entry pattern buffer and bit-serial output shifter
`timescale 1ns / 1ps

`include "bicolor_led_matrix_scan_shifter_defines.svh"

module blmss_serializer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pat_valid,
  input  blmss_pkg::pattern_t               pat,
  output logic                              pat_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_bit,
  output logic [blmss_pkg::POS_W-1:0]       out_pos,
  output logic [blmss_pkg::SLOT_W-1:0]      out_slot,
  output logic                              out_last
);

  logic                                 pend_valid_r;
  blmss_pkg::pattern_t                  pend_r;
  logic                                 sh_valid_r;
  logic [blmss_pkg::SHIFT_BITS-1:0]     sh_bits_r;
  logic [blmss_pkg::POS_W-1:0]          pos_r;
  logic [blmss_pkg::SLOT_W-1:0]         slot_r;

  logic out_fire;
  logic sh_done;
  logic sh_load;

  assign out_fire  = sh_valid_r && out_ready;
  assign sh_done   = out_fire && (pos_r == blmss_pkg::LAST_POS);
  assign sh_load   = pend_valid_r && (!sh_valid_r || sh_done);
  assign pat_ready = !pend_valid_r;

  // pending buffer lets a new item in while the shifter is busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (pat_valid && pat_ready) begin
      pend_valid_r <= 1'b1;
    end else if (sh_load) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_valid && pat_ready) begin
      pend_r <= pat;
    end
  end

  // shifter control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_valid_r <= 1'b0;
      pos_r      <= '0;
    end else if (sh_load) begin
      sh_valid_r <= 1'b1;
      pos_r      <= '0;
    end else if (sh_done) begin
      sh_valid_r <= 1'b0;
      pos_r      <= '0;
    end else if (out_fire) begin
      pos_r <= pos_r + blmss_pkg::POS_W'(1);
    end
  end

  // shifter payload
  always_ff @(posedge clk) begin
    if (sh_load) begin
      sh_bits_r <= pend_r.bits;
      slot_r    <= pend_r.slot;
    end else if (out_fire) begin
      sh_bits_r <= {1'b0, sh_bits_r[blmss_pkg::SHIFT_BITS-1:1]};
    end
  end

  assign out_valid = sh_valid_r;
  assign out_bit   = sh_bits_r[0];
  assign out_pos   = pos_r;
  assign out_slot  = slot_r;
  assign out_last  = (pos_r == blmss_pkg::LAST_POS);

  // checks
  `BLMSS_ASSERT_NOW(a_pos_range, clk, rst_n, sh_valid_r, pos_r <= blmss_pkg::LAST_POS, "shift position past last bit")
  `BLMSS_ASSERT_NEXT(a_pend_start, clk, rst_n, pend_valid_r && !sh_valid_r, sh_valid_r && (pos_r == '0) && !pend_valid_r, "pending pattern not started at bit zero")
  `BLMSS_ASSERT_NEXT(a_run_end, clk, rst_n, sh_done && !pend_valid_r, !sh_valid_r, "shifter kept running after last bit")

endmodule

[rtl/core/bicolor_led_matrix_scan_shifter.sv]
// top level of the bicolor led matrix scan shifter
`timescale 1ns / 1ps

// Each tick item (in_tuser = 1) produces 24 output items, one per cycle when out_tready
// stays high: 16 active-low row bits, then 8 column bits, with out_tlast on bit 23. A tick
// therefore occupies the output shifter until its last bit is taken; one more tick may be
// accepted and held in a one-entry buffer while the current slot shifts out. Load items
// (in_tuser = 0) replace both frames, produce no output and are accepted whenever the
// buffer is free. The pattern of a tick is taken from the frames stored at the moment the
// tick is accepted. The slot counter runs 0..127, column outer, red rows then yellow rows,
// and keeps its value across loads.

module bicolor_led_matrix_scan_shifter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [63:0] red_frame, [127:64] yellow_frame
  input  logic [127:0]  in_tdata,
  // [0] command
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [0] data_bit, [5:1] bit_position, [12:6] scan_slot, [15:13] zero
  output logic [15:0]   out_tdata,
  output logic          out_tlast
);

  logic                              in_fire;
  logic                              load_en;
  logic                              tick_en;
  blmss_pkg::pattern_t               pattern;
  logic                              pat_ready;
  logic                              ser_bit;
  logic [blmss_pkg::POS_W-1:0]       ser_pos;
  logic [blmss_pkg::SLOT_W-1:0]      ser_slot;

  // input handshake and command decode
  assign in_tready = pat_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign load_en   = in_fire && (in_tuser == blmss_pkg::CMD_LOAD);
  assign tick_en   = in_fire && (in_tuser == blmss_pkg::CMD_TICK);

  blmss_frame_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_en      (load_en),
    .tick_en      (tick_en),
    .red_frame    (in_tdata[63:0]),
    .yellow_frame (in_tdata[127:64]),
    .pattern      (pattern)
  );

  blmss_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .pat_valid (tick_en),
    .pat       (pattern),
    .pat_ready (pat_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bit   (ser_bit),
    .out_pos   (ser_pos),
    .out_slot  (ser_slot),
    .out_last  (out_tlast)
  );

  // pack the result item
  assign out_tdata = {3'b000, ser_slot, ser_pos, ser_bit};

endmodule

[tb/sv/bicolor_led_matrix_scan_shifter_checker.sv]
// checker for the led matrix scan shifter: tracks frames and slot, predicts and compares
`timescale 1ns / 1ps

module bicolor_led_matrix_scan_shifter_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // [63:0] red_frame, [127:64] yellow_frame
  input  logic [127:0] in_tdata,
  // [0] command
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [0] data_bit, [5:1] bit_position, [12:6] scan_slot, [15:13] zero
  input  logic [15:0]  out_tdata,
  input  logic         out_tlast,
  output int           n_errors,
  output int           n_pending
);

  localparam int ROW_N     = 16;
  localparam int COL_N     = 8;
  localparam int MAX_SHOWN = 10;

  // shift order of row lines and column lines along the chain
  localparam logic [3:0] ROW_SEQ [ROW_N] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd15,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd7
  };
  localparam logic [2:0] COL_SEQ [COL_N] = '{
    3'd4, 3'd5, 3'd6, 3'd7, 3'd3, 3'd2, 3'd1, 3'd0
  };

  typedef struct packed {
    logic       data_bit;
    logic [4:0] bit_pos;
    logic [6:0] scan_slot;
    logic       latch;
  } chain_bit_t;

  logic [63:0] frame_red;
  logic [63:0] frame_yellow;
  logic [6:0]  slot_idx;
  chain_bit_t  chain_bits_q[$];
  int          n_results;

  // queue the 24 chain bits of the current slot and advance the slot
  function automatic void queue_slot_pattern();
    logic [2:0]  col;
    logic        yellow;
    logic [2:0]  row;
    logic [63:0] frame;
    logic        lit;
    logic [3:0]  row_line;
    chain_bit_t  cb;
    col      = slot_idx[6:4];
    yellow   = slot_idx[3];
    row      = slot_idx[2:0];
    frame    = yellow ? frame_yellow : frame_red;
    lit      = frame[{row, col}];
    row_line = {yellow, row};
    for (int i = 0; i < ROW_N + COL_N; i++) begin
      cb.bit_pos   = 5'(i);
      cb.scan_slot = slot_idx;
      cb.latch     = (i == ROW_N + COL_N - 1);
      if (i < ROW_N) begin
        // active-low rows: only the lit dot's row goes low
        cb.data_bit = lit ? (ROW_SEQ[i] != row_line) : 1'b1;
      end else begin
        cb.data_bit = lit ? (COL_SEQ[i-ROW_N] == col) : 1'b0;
      end
      chain_bits_q.push_back(cb);
    end
    slot_idx = slot_idx + 7'd1;
  endfunction

  // count a failure, show the first few
  function automatic void flag_error(string what, chain_bit_t exp_cb, chain_bit_t got_cb);
    n_errors++;
    if (n_errors <= MAX_SHOWN) begin
      $display("[%0t] result %0d %s: expected bit=%0b pos=%0d slot=%0d last=%0b,",
               $realtime, n_results, what, exp_cb.data_bit, exp_cb.bit_pos,
               exp_cb.scan_slot, exp_cb.latch);
      $display("    got bit=%0b pos=%0d slot=%0d last=%0b",
               got_cb.data_bit, got_cb.bit_pos, got_cb.scan_slot, got_cb.latch);
    end
  endfunction

  // watch both channels, items accepted at the clock edge
  always @(posedge clk) begin
    chain_bit_t got_cb;
    chain_bit_t exp_cb;
    if (!rst_n) begin
      frame_red    = '0;
      frame_yellow = '0;
      slot_idx     = '0;
      chain_bits_q.delete();
      n_errors   = 0;
      n_pending <= 0;
      n_results  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == blmss_pkg::CMD_TICK) begin
          queue_slot_pattern();
        end else begin
          frame_red    = in_tdata[63:0];
          frame_yellow = in_tdata[127:64];
        end
      end
      if (out_tvalid && out_tready) begin
        got_cb.data_bit  = out_tdata[0];
        got_cb.bit_pos   = out_tdata[5:1];
        got_cb.scan_slot = out_tdata[12:6];
        got_cb.latch     = out_tlast;
        if (chain_bits_q.size() == 0) begin
          flag_error("with nothing pending", '0, got_cb);
        end else begin
          exp_cb = chain_bits_q.pop_front();
          if (got_cb.data_bit !== exp_cb.data_bit) flag_error("data bit", exp_cb, got_cb);
          if (got_cb.bit_pos !== exp_cb.bit_pos) flag_error("bit position", exp_cb, got_cb);
          if (got_cb.scan_slot !== exp_cb.scan_slot) flag_error("scan slot", exp_cb, got_cb);
          if (got_cb.latch !== exp_cb.latch) flag_error("latch mark", exp_cb, got_cb);
          if (out_tdata[15:13] !== 3'b000) flag_error("pad bits set", exp_cb, got_cb);
        end
        n_results++;
      end
      n_pending <= chain_bits_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// testbench top of the led matrix scan shifter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_CYCLES  = 400;
  localparam int WATCH_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic         out_tlast;
  int           n_errors;
  int           n_pending;

  int send_idle_pct  = 36;
  int recv_stall_pct = 68;
  bit hold_go = 1'b0;

  bicolor_led_matrix_scan_shifter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  bicolor_led_matrix_scan_shifter_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .n_errors   (n_errors),
    .n_pending  (n_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no item accepted on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) break;
    end
    $display("Mismatches found");
    $finish;
  end

  // offer one item after random idle cycles, return at the edge that accepts it
  task automatic send_item(logic cmd, logic [63:0] red, logic [63:0] yellow);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {yellow, red};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic [63:0] rand_frame();
    logic [63:0] f;
    f = {$urandom, $urandom};
    case ($urandom_range(5))
      0: f = '0;
      1: f = '1;
      2: f = f & {$urandom, $urandom};
      3: f = f | {$urandom, $urandom};
      default: ;
    endcase
    return f;
  endfunction

  // mostly ticks, some loads; tick items carry junk frame data
  task automatic send_random(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 25) begin
        send_item(blmss_pkg::CMD_LOAD, rand_frame(), rand_frame());
      end else begin
        send_item(blmss_pkg::CMD_TICK, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dot off right after reset
    send_item(blmss_pkg::CMD_TICK, '0, '0);
    // all dots lit: walk red rows, yellow rows and into the next column
    send_item(blmss_pkg::CMD_LOAD, '1, '1);
    repeat (17) send_item(blmss_pkg::CMD_TICK, '1, '0);
    // red off, yellow lit
    send_item(blmss_pkg::CMD_LOAD, '0, '1);
    repeat (2) send_item(blmss_pkg::CMD_TICK, '0, '0);
    // checkerboard frames
    send_item(blmss_pkg::CMD_LOAD, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    repeat (2) send_item(blmss_pkg::CMD_TICK, '0, '0);

    // receiver stalls more than sender idles, then a full drain
    send_random(66);
    wait_all_results();

    // sender idles more than receiver stalls
    send_idle_pct  = 68;
    recv_stall_pct = 36;
    send_random(90);

    // no idling; receiver holds off while ticks keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    send_random(100);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
